// File: rtl/core/bf3_pkg.sv
package bf3_pkg;

    // pixel and running sum widths
    localparam int PIX_W   = 8;
    localparam int COL2_W  = 9;    // two pixels of one column
    localparam int COL3_W  = 10;   // three pixels of one column
    localparam int SUM_W   = 12;   // up to nine pixels

    // configuration
    localparam int SIDE_W        = 6;
    localparam int MAX_SIDE_DEF  = 32;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam logic REG_IDX_SIDE = 1'b0;

    // queue depths (powers of two)
    localparam int JQ_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;

    // result kinds a word can cause, in emission order
    localparam int NUM_KIND       = 5;
    localparam int KIND_PASS      = 0;  // side of one, pixel passes through
    localparam int KIND_UPPER     = 1;  // row above, center column c-1
    localparam int KIND_LOWER     = 2;  // bottom row, center column c-1
    localparam int KIND_UPPER_END = 3;  // row above, last column
    localparam int KIND_LOWER_END = 4;  // bottom row, last column

    typedef struct packed {
        logic [2:0][COL3_W-1:0] col3;   // [2] column c, [1] c-1, [0] c-2
        logic [2:0][COL2_W-1:0] col2;
        logic [NUM_KIND-1:0]    kinds;
        logic                   rows3;  // row r-2 takes part
        logic                   left_ok; // column c-2 lies inside the image
    } bf3_job_t;

endpackage

// File: rtl/core/box_filter_3x3_edge_clipped_core.sv
// 3x3 box filter with the window clipped at the image border
//
// input channel: one 8-bit pixel word per push, raster order, square image
// of side pixels; a word is taken on a clock edge with push high, full low
// result channel: a queue read port; while empty is low the oldest result
// word sits on smoothed / last_in_burst / end_of_image and pop takes it
// config: APB register side at address 0 (6 bits, reset 32); 0 acts as 1 and
// values above MAX_SIDE act as MAX_SIDE; any write to it restarts the image
//
// throughput: one pixel per cycle through the row store pipeline while full is low;
// the result side emits one word per cycle while its queue has room, so on the bottom
// row (two results per pixel) and at image end (up to four) input runs at the result rate
// a result word passes the second stage, the job queue and the s1 and s2 registers
// before it shows on the queue; in image terms results lag one row plus one pixel
// a stalled reader fills the 4-word result queue, then the 4-entry job queue,
// then full rises; nothing is dropped
// reset: counters return to the top left corner, both queues empty, side 32;
// the row stores hold nothing valid until rows of a new image pass through
module box_filter_3x3_edge_clipped_core
    import bf3_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // apb configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // pixel input
    input  logic [PIX_W-1:0]  pixel,
    input  logic              push,
    output logic              full,
    // result output
    output logic [PIX_W-1:0]  smoothed,
    output logic              last_in_burst,
    output logic              end_of_image,
    output logic              empty,
    input  logic              pop
);

    logic [SIDE_W-1:0] side_reg, side_next;
    logic              side_wr;
    bf3_job_t          fe_job, be_job;
    logic              job_push, jq_full, jq_empty, jq_pop;

    // register file: a single register, byte offset ignored
    assign pready  = 1'b1;
    assign side_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_SIDE);
    assign side_next = side_wr ? pwdata[SIDE_W-1:0] : side_reg;
    assign prdata  = (paddr[2] == REG_IDX_SIDE) ? DATA_W'(side_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else
        begin
            side_reg <= side_next;
        end
    end

    // front: position tracking, row stores, column sums, result classification
    bf3_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .side     (side_reg),
        .restart  (side_wr),
        .pixel    (pixel),
        .push     (push),
        .full     (full),
        .job      (fe_job),
        .job_push (job_push),
        .jq_full  (jq_full)
    );

    // short queue decoupling the pixel side from the result side
    bf3_job_queue u_job_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (fe_job),
        .full   (jq_full),
        .rd_en  (jq_pop),
        .rd_job (be_job),
        .empty  (jq_empty)
    );

    // back: sum, reciprocal multiply, result queue; one result per cycle while it has room
    bf3_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (be_job),
        .jq_empty      (jq_empty),
        .jq_pop        (jq_pop),
        .smoothed      (smoothed),
        .last_in_burst (last_in_burst),
        .end_of_image  (end_of_image),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

// File: rtl/core/bf3_job_queue.sv
module bf3_job_queue
    import bf3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  bf3_job_t wr_job,
    output logic     full,
    input  logic     rd_en,
    output bf3_job_t rd_job,
    output logic     empty
);

    localparam int PW = $clog2(JQ_DEPTH);

    bf3_job_t        entry_reg [JQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_wr, do_rd;

    assign full   = (count_reg == (PW+1)'(JQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// File: rtl/core/bf3_front.sv
module bf3_front
    import bf3_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIDE_W-1:0] side,
    input  logic              restart,
    input  logic [PIX_W-1:0]  pixel,
    input  logic              push,
    output logic              full,
    output bf3_job_t          job,
    output logic              job_push,
    input  logic              jq_full
);

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    // line stores: row r-2 and row r-1
    logic [PIX_W-1:0]  upper_mem  [MAX_SIDE];
    logic [PIX_W-1:0]  middle_mem [MAX_SIDE];

    logic [AW-1:0]     last_idx;
    logic [AW-1:0]     row_reg, row_next;
    logic [AW-1:0]     col_reg, col_next;
    logic              accept;
    logic [NUM_KIND-1:0] kinds;
    logic              last_row, last_col, row_ge1, row_ge2, col_ge1, col_ge2, pass;

    // second stage
    logic              f1_valid_reg, f1_valid_next;
    logic [AW-1:0]     f1_col_reg;
    logic [PIX_W-1:0]  f1_pixel_reg;
    logic [NUM_KIND-1:0] f1_kinds_reg;
    logic              f1_top_reg, f1_mid_reg, f1_left_reg;
    logic [PIX_W-1:0]  upper_rd_reg, middle_rd_reg;
    logic              f1_adv;
    logic [COL3_W-1:0] cur3;
    logic [COL2_W-1:0] cur2;

    // column sums of c-2 ([0]) and c-1 ([1])
    logic [COL3_W-1:0] win3_reg [2];
    logic [COL2_W-1:0] win2_reg [2];

    always_comb
    begin
        if (side == '0)
        begin
            last_idx = '0;
        end
        else if (side > SIDE_W'(MAX_SIDE))
        begin
            last_idx = AW'(MAX_SIDE - 1);
        end
        else
        begin
            last_idx = AW'(side - SIDE_W'(1));
        end
    end

    assign accept   = push && !full;
    assign pass     = (last_idx == '0);
    assign last_row = (row_reg == last_idx);
    assign last_col = (col_reg == last_idx);
    assign row_ge1  = (row_reg != '0);
    assign row_ge2  = (row_reg > AW'(1));
    assign col_ge1  = (col_reg != '0);
    assign col_ge2  = (col_reg > AW'(1));

    always_comb
    begin
        kinds = '0;
        if (pass)
        begin
            kinds[KIND_PASS] = 1'b1;
        end
        else
        begin
            kinds[KIND_UPPER]     = col_ge1 && row_ge1;
            kinds[KIND_LOWER]     = col_ge1 && last_row;
            kinds[KIND_UPPER_END] = last_col && row_ge1;
            kinds[KIND_LOWER_END] = last_col && last_row;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + AW'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    // stage moves on unless a word with results finds the queue full
    assign f1_adv   = f1_valid_reg && (!jq_full || (f1_kinds_reg == '0));
    assign full     = f1_valid_reg && !f1_adv;
    assign job_push = f1_valid_reg && (f1_kinds_reg != '0) && !jq_full;

    always_comb
    begin
        if (accept)
        begin
            f1_valid_next = 1'b1;
        end
        else if (f1_adv)
        begin
            f1_valid_next = 1'b0;
        end
        else
        begin
            f1_valid_next = f1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_col_reg    <= col_reg;
            f1_pixel_reg  <= pixel;
            f1_kinds_reg  <= kinds;
            f1_top_reg    <= row_ge2;
            f1_mid_reg    <= row_ge1;
            f1_left_reg   <= col_ge2;
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (f1_adv)
        begin
            // rows move down one place as the column is passed
            upper_mem[f1_col_reg]  <= middle_rd_reg;
            middle_mem[f1_col_reg] <= f1_pixel_reg;
            win3_reg[0] <= win3_reg[1];
            win3_reg[1] <= cur3;
            win2_reg[0] <= win2_reg[1];
            win2_reg[1] <= cur2;
        end
    end

    always_comb
    begin
        cur3 = COL3_W'(f1_pixel_reg)
             + (f1_mid_reg ? COL3_W'(middle_rd_reg) : '0)
             + (f1_top_reg ? COL3_W'(upper_rd_reg) : '0);
        cur2 = COL2_W'(f1_pixel_reg)
             + (f1_mid_reg ? COL2_W'(middle_rd_reg) : '0);
    end

    always_comb
    begin
        job.col3    = {cur3, win3_reg[1], win3_reg[0]};
        job.col2    = {cur2, win2_reg[1], win2_reg[0]};
        job.kinds   = f1_kinds_reg;
        job.rows3   = f1_top_reg;
        job.left_ok = f1_left_reg;
    end

endmodule

// File: rtl/core/bf3_back.sv
module bf3_back
    import bf3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bf3_job_t         job,
    input  logic             jq_empty,
    output logic             jq_pop,
    output logic [PIX_W-1:0] smoothed,
    output logic             last_in_burst,
    output logic             end_of_image,
    output logic             empty,
    input  logic             pop
);

    // floor(sum / d) = (sum * k) >> FRAC for every sum below 2^SUM_W
    localparam int RECIP_W = 16;
    localparam int FRAC    = 15;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_DIV1 = 16'd32768;
    localparam logic [RECIP_W-1:0] RECIP_DIV4 = 16'd8192;
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = 16'd5462;
    localparam logic [RECIP_W-1:0] RECIP_DIV9 = 16'd3641;
    localparam int OPW = $clog2(OUT_DEPTH);

    logic [NUM_KIND-1:0] done_reg, done_next;
    logic [NUM_KIND-1:0] remaining, pick;
    logic                is_last, room, issue;
    logic                use3, rows3, left, mid_col;
    logic [COL3_W-1:0]   c0, c1, c2;
    logic [SUM_W-1:0]    sum;
    logic [RECIP_W-1:0]  recip;
    logic                eoi;

    logic                s1_valid_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [RECIP_W-1:0]  s1_recip_reg;
    logic                s1_last_reg, s1_eoi_reg;
    logic                s2_valid_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic                s2_last_reg, s2_eoi_reg;

    logic [PIX_W-1:0]    out_pix_reg  [OUT_DEPTH];
    logic                out_last_reg [OUT_DEPTH];
    logic                out_eoi_reg  [OUT_DEPTH];
    logic [OPW-1:0]      owr_ptr_reg, ord_ptr_reg;
    logic [OPW:0]        ocnt_reg, ocnt_next;
    logic                o_rd;

    assign remaining = job.kinds & ~done_reg;
    assign pick      = remaining & (~remaining + NUM_KIND'(1));
    assign is_last   = ((remaining & ~pick) == '0);
    assign room      = ((ocnt_reg + (OPW+1)'(s1_valid_reg) + (OPW+1)'(s2_valid_reg))
                        < (OPW+1)'(OUT_DEPTH));
    assign issue     = !jq_empty && room;
    assign jq_pop    = issue && is_last;

    always_comb
    begin
        done_next = done_reg;
        if (issue)
        begin
            done_next = is_last ? '0 : (done_reg | pick);
        end
    end

    // window selection for the chosen result
    always_comb
    begin
        use3    = pick[KIND_PASS] || pick[KIND_UPPER] || pick[KIND_UPPER_END];
        rows3   = (pick[KIND_UPPER] || pick[KIND_UPPER_END]) && job.rows3;
        left    = (pick[KIND_UPPER] || pick[KIND_LOWER]) && job.left_ok;
        mid_col = !pick[KIND_PASS];
        eoi     = pick[KIND_PASS] || pick[KIND_LOWER_END];
        if (use3)
        begin
            c0 = job.col3[0];
            c1 = job.col3[1];
            c2 = job.col3[2];
        end
        else
        begin
            c0 = COL3_W'(job.col2[0]);
            c1 = COL3_W'(job.col2[1]);
            c2 = COL3_W'(job.col2[2]);
        end
        sum = SUM_W'(c2)
            + (mid_col ? SUM_W'(c1) : '0)
            + (left ? SUM_W'(c0) : '0);
        if (pick[KIND_PASS])
        begin
            recip = RECIP_DIV1;
        end
        else if (rows3 && left)
        begin
            recip = RECIP_DIV9;
        end
        else if (rows3 || left)
        begin
            recip = RECIP_DIV6;
        end
        else
        begin
            recip = RECIP_DIV4;
        end
    end

    assign o_rd = pop && !empty;

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (s2_valid_reg && !o_rd)
        begin
            ocnt_next = ocnt_reg + (OPW+1)'(1);
        end
        else if (o_rd && !s2_valid_reg)
        begin
            ocnt_next = ocnt_reg - (OPW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            owr_ptr_reg  <= '0;
            ord_ptr_reg  <= '0;
            ocnt_reg     <= '0;
        end
        else
        begin
            done_reg     <= done_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                owr_ptr_reg <= owr_ptr_reg + OPW'(1);
            end
            if (o_rd)
            begin
                ord_ptr_reg <= ord_ptr_reg + OPW'(1);
            end
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sum_reg   <= sum;
        s1_recip_reg <= recip;
        s1_last_reg  <= is_last;
        s1_eoi_reg   <= eoi;
        s2_prod_reg  <= PROD_W'(s1_sum_reg) * PROD_W'(s1_recip_reg);
        s2_last_reg  <= s1_last_reg;
        s2_eoi_reg   <= s1_eoi_reg;
        if (s2_valid_reg)
        begin
            out_pix_reg[owr_ptr_reg]  <= s2_prod_reg[FRAC+PIX_W-1:FRAC];
            out_last_reg[owr_ptr_reg] <= s2_last_reg;
            out_eoi_reg[owr_ptr_reg]  <= s2_eoi_reg;
        end
    end

    assign empty         = (ocnt_reg == '0);
    assign smoothed      = out_pix_reg[ord_ptr_reg];
    assign last_in_burst = out_last_reg[ord_ptr_reg];
    assign end_of_image  = out_eoi_reg[ord_ptr_reg];

endmodule

// File: bench/tb_box_filter_3x3_edge_clipped_core.sv
module tb_box_filter_3x3_edge_clipped_core
    import bf3_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // register map: side is register 0, one slot past it is unmapped
    localparam logic [ADDR_W-1:0] ADDR_SIDE   = ADDR_W'(4 * int'(REG_IDX_SIDE));
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4 * (int'(REG_IDX_SIDE) + 1));

    localparam int LINE_DEPTH    = MAX_SIDE_DEF;
    localparam int SETTLE_CYCLES = 8;    // pipeline depth plus padding
    localparam int HOLD_CYCLES   = 300;  // long reader hold-off
    localparam int SMALL_TARGET  = 250;  // pixels in the small random images

    typedef enum logic {
        STEP_WRITE,
        STEP_PIXEL
    } step_kind_t;

    // one row of the directed plan; typed rows carry their expected burst
    // as n_exp copies of exp_val, flags on the final word
    typedef struct packed {
        step_kind_t        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [2:0]        n_exp;
        logic [PIX_W-1:0]  exp_val;
        logic              exp_eoi;
    } plan_row_t;

    // one word on the result side
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last_flag;
        logic             eoi_flag;
    } smooth_word_t;

    localparam int PLAN_LEN = 31;
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // side 32 out of reset: the first row yields nothing
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h80, 1'b1, 3'd0, 8'h00, 1'b0},
        // side of one passes every pixel straight through
        '{STEP_WRITE, ADDR_SIDE,   32'd1,  1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b1, 3'd1, 8'h00, 1'b1},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b1, 3'd1, 8'hFF, 1'b1},
        '{STEP_PIXEL, ADDR_SIDE,   32'h5A, 1'b1, 3'd1, 8'h5A, 1'b1},
        // unmapped register: write dropped, side stays one
        '{STEP_WRITE, ADDR_UNUSED, 32'd2,  1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h3C, 1'b1, 3'd1, 8'h3C, 1'b1},
        // side zero behaves as one
        '{STEP_WRITE, ADDR_SIDE,   32'd0,  1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h81, 1'b1, 3'd1, 8'h81, 1'b1},
        // 2x2 all white: only the last pixel flushes, four words of 255
        '{STEP_WRITE, ADDR_SIDE,   32'd2,  1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b1, 3'd4, 8'hFF, 1'b1},
        // same with all black, rewriting the same side
        '{STEP_WRITE, ADDR_SIDE,   32'd2,  1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b1, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b1, 3'd4, 8'h00, 1'b1},
        // 3x3 checkerboard: corner, edge and interior divisors
        '{STEP_WRITE, ADDR_SIDE,   32'd3,  1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'h00, 1'b0, 3'd0, 8'h00, 1'b0},
        '{STEP_PIXEL, ADDR_SIDE,   32'hFF, 1'b0, 3'd0, 8'h00, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic [PIX_W-1:0]  pixel;
    logic              push;
    logic              full;
    logic [PIX_W-1:0]  smoothed;
    logic              last_in_burst;
    logic              end_of_image;
    logic              empty;
    logic              pop;

    // filter model state: the side register and the three row stores
    logic [SIDE_W-1:0] side_reg;
    logic [PIX_W-1:0]  line_top [LINE_DEPTH];
    logic [PIX_W-1:0]  line_mid [LINE_DEPTH];
    logic [PIX_W-1:0]  line_new [LINE_DEPTH];
    int                row_pos;
    int                col_pos;

    smooth_word_t      burst_words [$];     // words caused by the latest pixel
    smooth_word_t      expected_words [$];  // words still owed by the block

    int  error_count;
    int  words_checked;
    int  pixels_sent;
    int  settings_done;
    int  full_cycles;
    bit  no_gaps;
    bit  squeeze;
    bit  squeeze_done;
    int  stall_left;
    int  pop_rate;

    box_filter_3x3_edge_clipped_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel         (pixel),
        .push          (push),
        .full          (full),
        .smoothed      (smoothed),
        .last_in_burst (last_in_burst),
        .end_of_image  (end_of_image),
        .empty         (empty),
        .pop           (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #1ms;
        $display("tb_box_filter_3x3_edge_clipped_core: FAIL");
        $finish;
    end

    // side as the datapath sees it: 0 acts as 1, above the max clamps
    function automatic int active_side();
        if (side_reg == '0)
            return 1;
        if (int'(side_reg) > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(side_reg);
    endfunction

    // truncated mean over the clipped window around col; middle and new
    // rows always count, the top row only when the window has three rows
    function automatic logic [PIX_W-1:0] window_avg(input int col, input int n,
                                                    input bit with_top);
        int lo;
        int hi;
        int sum;
        int cnt;
        lo  = (col > 0) ? col - 1 : 0;
        hi  = (col + 1 < n) ? col + 1 : n - 1;
        sum = 0;
        cnt = 0;
        for (int k = lo; k <= hi; k++)
        begin
            sum += int'(line_mid[k]) + int'(line_new[k]);
            cnt += 2;
            if (with_top)
            begin
                sum += int'(line_top[k]);
                cnt++;
            end
        end
        return PIX_W'(sum / cnt);
    endfunction

    // advance the filter model by one pixel, leaving its burst in burst_words
    task automatic filter_pixel(input logic [PIX_W-1:0] px);
        int n;
        int r;
        int c;
        bit bottom;
        bit with_top;
        n = active_side();
        r = row_pos;
        c = col_pos;
        burst_words.delete();
        if (n == 1)
        begin
            row_pos = 0;
            col_pos = 0;
            burst_words.push_back('{px, 1'b1, 1'b1});
            return;
        end
        if (r >= n || c >= n)
        begin
            r = 0;
            c = 0;
        end
        line_new[c] = px;
        bottom      = (r == n - 1);
        with_top    = (r >= 2);
        // centre column c-1 of the row above, then of the bottom row
        if (c >= 1)
        begin
            if (r >= 1)
                burst_words.push_back('{window_avg(c - 1, n, with_top), 1'b0, 1'b0});
            if (bottom)
                burst_words.push_back('{window_avg(c - 1, n, 1'b0), 1'b0, 1'b0});
        end
        // end of row: last column too, then the row stores shift up
        if (c == n - 1)
        begin
            if (r >= 1)
                burst_words.push_back('{window_avg(n - 1, n, with_top), 1'b0, 1'b0});
            if (bottom)
                burst_words.push_back('{window_avg(n - 1, n, 1'b0), 1'b0, 1'b1});
            line_top = line_mid;
            line_mid = line_new;
            c = 0;
            r = bottom ? 0 : r + 1;
        end
        else
        begin
            c++;
        end
        row_pos = r;
        col_pos = c;
        if (burst_words.size() > 0)
            burst_words[burst_words.size() - 1].last_flag = 1'b1;
    endtask

    // sender gap: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one pixel word and hold it until taken; the expected burst is
    // queued at the edge that takes it
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input int n_typed, input logic [PIX_W-1:0] typed_val,
                              input bit typed_eoi);
        int gap;
        push  <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (full)
        begin
            full_cycles++;
            @(posedge clk);
        end
        filter_pixel(px);
        if (typed)
        begin
            for (int i = 0; i < n_typed; i++)
                expected_words.push_back('{typed_val, 1'(i == n_typed - 1),
                                           1'(typed_eoi && i == n_typed - 1)});
        end
        else
        begin
            foreach (burst_words[i])
                expected_words.push_back(burst_words[i]);
        end
        pixels_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending, let every owed word come out, then let the pipeline
    // settle so that pixels with no result are through too
    task automatic drain_results();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // only register 0 exists; a write to it restarts the image
        if (int'(addr >> 2) == int'(REG_IDX_SIDE))
        begin
            side_reg = data[SIDE_W-1:0];
            row_pos  = 0;
            col_pos  = 0;
        end
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write a register with the block idle, then read side back
    task automatic program_side(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] readback;
        drain_results();
        apb_write(addr, data);
        apb_read(ADDR_SIDE, readback);
        settings_done++;
        if (readback !== DATA_W'(side_reg))
        begin
            $display("%0t side readback: expected %h actual %h", $time,
                     DATA_W'(side_reg), readback);
            error_count++;
        end
    endtask

    // one random image phase: set the side, then stream pixels whose
    // content follows one of a few patterns
    task automatic run_phase(input int side_val, input int n_pixels, input bit gapless,
                             input bit hold_reader);
        int unsigned       mode;
        logic [PIX_W-1:0]  base;
        logic [PIX_W-1:0]  px;
        logic [DATA_W-1:0] wdata;
        if ($urandom_range(0, 9) == 0)
            program_side(ADDR_UNUSED, $urandom);
        // upper data bits are random, only the low six reach the register
        wdata = ($urandom & ~DATA_W'(2**SIDE_W - 1)) | DATA_W'(side_val);
        program_side(ADDR_SIDE, wdata);
        no_gaps = gapless;
        squeeze = hold_reader;
        mode    = $urandom_range(0, 9);
        base    = PIX_W'($urandom);
        for (int i = 0; i < n_pixels; i++)
        begin
            case (mode)
                6, 7:    px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                8:       px = base;
                9:       px = base ^ PIX_W'($urandom_range(0, 7));
                default: px = PIX_W'($urandom);
            endcase
            send_pixel(px, 1'b0, 0, '0, 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    // result side: check each taken word against the oldest owed one, then
    // choose pop for the next edge
    initial
    begin
        smooth_word_t want;
        pop          <= 1'b0;
        squeeze_done  = 1'b0;
        stall_left    = 0;
        pop_rate      = 100;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected word: expected none actual %h/%b/%b", $time,
                             smoothed, last_in_burst, end_of_image);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (smoothed !== want.value)
                    begin
                        $display("%0t smoothed: expected %h actual %h", $time,
                                 want.value, smoothed);
                        error_count++;
                    end
                    if (last_in_burst !== want.last_flag)
                    begin
                        $display("%0t last_in_burst: expected %b actual %b", $time,
                                 want.last_flag, last_in_burst);
                        error_count++;
                    end
                    if (end_of_image !== want.eoi_flag)
                    begin
                        $display("%0t end_of_image: expected %b actual %b", $time,
                                 want.eoi_flag, end_of_image);
                        error_count++;
                    end
                end
                words_checked++;
                // change the reader's appetite every 64 words
                if (words_checked % 64 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       pop_rate = 100;
                        1:       pop_rate = 85;
                        2:       pop_rate = 50;
                        default: pop_rate = 25;
                    endcase
                end
            end
            // one long hold-off so the block backs up to full
            if (squeeze && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                stall_left = $urandom_range(10, 50);
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(1, 100) <= pop_rate);
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned roll;
        int          side_pick;
        int          n_act;
        int          n_pixels;
        int          small_start;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        pixel    <= '0;
        push     <= 1'b0;
        rst_n    <= 1'b0;
        error_count   = 0;
        words_checked = 0;
        pixels_sent   = 0;
        settings_done = 0;
        full_cycles   = 0;
        no_gaps       = 1'b0;
        squeeze       = 1'b0;
        side_reg      = SIDE_RESET;
        row_pos       = 0;
        col_pos       = 0;
        for (int k = 0; k < LINE_DEPTH; k++)
        begin
            line_top[k] = '0;
            line_mid[k] = '0;
            line_new[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == STEP_WRITE)
                program_side(DIRECTED_PLAN[i].addr, DIRECTED_PLAN[i].data);
            else
                send_pixel(DIRECTED_PLAN[i].data[PIX_W-1:0], DIRECTED_PLAN[i].typed,
                           int'(DIRECTED_PLAN[i].n_exp), DIRECTED_PLAN[i].exp_val,
                           DIRECTED_PLAN[i].exp_eoi);
        end

        // clamped sides, a part image each; the second one runs flat out
        // while the reader holds off
        run_phase(33, $urandom_range(40, 100), 1'b0, 1'b0);
        run_phase(63, $urandom_range(120, 160), 1'b1, 1'b1);

        // small images, whole or cut short by the next register write
        small_start = pixels_sent;
        while (pixels_sent - small_start < SMALL_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                side_pick = $urandom_range(0, 1);
            else if (roll < 25)
                side_pick = 2;
            else if (roll < 45)
                side_pick = 3;
            else if (roll < 85)
                side_pick = $urandom_range(4, 8);
            else
                side_pick = $urandom_range(9, 16);
            n_act = (side_pick < 1) ? 1 : side_pick;
            if (n_act == 1)
                n_pixels = $urandom_range(1, 12);
            else if ($urandom_range(0, 4) == 0)
                n_pixels = $urandom_range(1, n_act * n_act - 1);
            else if (n_act <= 8)
                n_pixels = n_act * n_act * $urandom_range(1, 2);
            else
                n_pixels = n_act * n_act;
            run_phase(side_pick, n_pixels, ($urandom_range(0, 3) == 0), 1'b0);
        end

        drain_results();
        $display("%0d pixels streamed over %0d register settings, %0d filtered words compared",
                 pixels_sent, settings_done, words_checked);
        $display("input held off by full for %0d cycles, %0d mismatches seen",
                 full_cycles, error_count);
        if (error_count == 0)
            $display("tb_box_filter_3x3_edge_clipped_core: PASS");
        else
            $display("tb_box_filter_3x3_edge_clipped_core: FAIL");
        $finish;
    end

endmodule
